// ===== rtl/pxe_dhcp_request_classifier_top_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef PXE_DHCP_REQUEST_CLASSIFIER_TOP_MACROS_SVH
`define PXE_DHCP_REQUEST_CLASSIFIER_TOP_MACROS_SVH

// Check a property on every rising edge once reset is released.
`define PXEDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define PXEDC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/pxedc_pkg.sv =====
`timescale 1ns / 1ps

package pxedc_pkg;

    localparam int unsigned HDR_LEN = 240;
    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TOO_SHORT = 3'd1,
        STATUS_NOT_REQ   = 3'd2,
        STATUS_BAD_COOKIE = 3'd3,
        STATUS_NOT_PXE   = 3'd4,
        STATUS_BAD_TYPE  = 3'd5
    } status_t;

    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;
    localparam logic [2:0] REPLY_NONE   = 3'd0;
    localparam logic [2:0] REPLY_OFFER  = 3'd2;
    localparam logic [2:0] REPLY_ACK    = 3'd5;

    // Control into the option walker.
    typedef struct packed {
        logic       byte_en;
        logic       clear;
        logic [7:0] data;
    } walk_ctrl_t;

    // Verdict inputs from the option walker, including the current word.
    typedef struct packed {
        logic [7:0] msg_type;
        logic       pxe_seen;
    } walk_stat_t;

endpackage

// ===== rtl/pxe_dhcp_request_classifier_top.sv =====
`timescale 1ns / 1ps
// The verdict is registered: m_valid is set by the same edge that takes the last word.
// Throughput: one word per cycle, set by the single-pass option walker and header
// capture that see each word once.
// A last word stalls only while the previous verdict waits in the result register.
// Reset: aresetn is synchronous and active low; it clears all parsing state and
// the result valid flag, and the state returns to reset after every verdict.

`include "pxe_dhcp_request_classifier_top_macros.svh"

module pxe_dhcp_request_classifier_top #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_respond,
    output logic [2:0]  m_status,
    output logic [2:0]  m_reply_msg_type,
    output logic [31:0] m_transaction_id,
    output logic [15:0] m_bootp_flags,
    output logic [7:0]  m_hw_type,
    output logic [7:0]  m_hw_len,
    output logic [31:0] m_relay_addr,
    output logic [47:0] m_client_hw_addr
);

    localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKET_BYTES);
    localparam logic [CW-1:0] HDR_END = CW'(pxedc_pkg::HDR_LEN);

    logic accept, accept_last;
    logic [CW-1:0] count_reg, count_next;
    logic op_ok_reg, op_ok_next;
    logic cookie_ok_reg, cookie_ok_next;
    logic [31:0] xid_reg, xid_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  htype_reg, htype_next;
    logic [7:0]  hlen_reg, hlen_next;
    logic [31:0] giaddr_reg, giaddr_next;
    logic [47:0] chaddr_reg, chaddr_next;
    logic hdr_en;

    pxedc_pkg::walk_ctrl_t walk_ctrl;
    pxedc_pkg::walk_stat_t walk_stat;
    pxedc_pkg::status_t    status_next;

    logic        m_valid_reg, m_valid_next;
    logic        respond_reg;
    logic [2:0]  status_reg;
    logic [2:0]  reply_reg;
    logic [31:0] xid_out_reg;
    logic [15:0] flags_out_reg;
    logic [7:0]  htype_out_reg;
    logic [7:0]  hlen_out_reg;
    logic [31:0] giaddr_out_reg;
    logic [47:0] chaddr_out_reg;

    // Only a last word needs a free result slot.
    assign s_ready     = !m_valid_reg || m_ready || !s_last;
    assign accept      = s_valid && s_ready;
    assign accept_last = accept && s_last;
    assign hdr_en      = accept && (count_reg < HDR_END);

    assign count_next = (accept && count_reg < CNT_MAX) ? count_reg + CW'(1) : count_reg;

    always_comb begin
        op_ok_next     = op_ok_reg;
        cookie_ok_next = cookie_ok_reg;
        xid_next       = xid_reg;
        flags_next     = flags_reg;
        htype_next     = htype_reg;
        hlen_next      = hlen_reg;
        giaddr_next    = giaddr_reg;
        chaddr_next    = chaddr_reg;
        if (hdr_en) begin
            case (count_reg)
                CW'(0):   op_ok_next = (s_data_byte == 8'd1);
                CW'(1):   htype_next = s_data_byte;
                CW'(2):   hlen_next  = s_data_byte;
                CW'(4):   xid_next[31:24] = s_data_byte;
                CW'(5):   xid_next[23:16] = s_data_byte;
                CW'(6):   xid_next[15:8]  = s_data_byte;
                CW'(7):   xid_next[7:0]   = s_data_byte;
                CW'(10):  flags_next[15:8] = s_data_byte;
                CW'(11):  flags_next[7:0]  = s_data_byte;
                CW'(24):  giaddr_next[31:24] = s_data_byte;
                CW'(25):  giaddr_next[23:16] = s_data_byte;
                CW'(26):  giaddr_next[15:8]  = s_data_byte;
                CW'(27):  giaddr_next[7:0]   = s_data_byte;
                CW'(28):  chaddr_next[47:40] = s_data_byte;
                CW'(29):  chaddr_next[39:32] = s_data_byte;
                CW'(30):  chaddr_next[31:24] = s_data_byte;
                CW'(31):  chaddr_next[23:16] = s_data_byte;
                CW'(32):  chaddr_next[15:8]  = s_data_byte;
                CW'(33):  chaddr_next[7:0]   = s_data_byte;
                CW'(236): cookie_ok_next = (s_data_byte == pxedc_pkg::MAGIC_COOKIE[31:24]);
                CW'(237): cookie_ok_next = cookie_ok_reg &&
                                           (s_data_byte == pxedc_pkg::MAGIC_COOKIE[23:16]);
                CW'(238): cookie_ok_next = cookie_ok_reg &&
                                           (s_data_byte == pxedc_pkg::MAGIC_COOKIE[15:8]);
                CW'(239): cookie_ok_next = cookie_ok_reg &&
                                           (s_data_byte == pxedc_pkg::MAGIC_COOKIE[7:0]);
                default: begin
                end
            endcase
        end
    end

    assign walk_ctrl.byte_en = accept && !(count_reg < HDR_END);
    assign walk_ctrl.clear   = accept_last;
    assign walk_ctrl.data    = s_data_byte;

    pxedc_opt_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (walk_ctrl),
        .stat    (walk_stat)
    );

    // First failing check wins.
    always_comb begin
        if (count_next < HDR_END) begin
            status_next = pxedc_pkg::STATUS_TOO_SHORT;
        end else if (!op_ok_next) begin
            status_next = pxedc_pkg::STATUS_NOT_REQ;
        end else if (!cookie_ok_next) begin
            status_next = pxedc_pkg::STATUS_BAD_COOKIE;
        end else if (!walk_stat.pxe_seen) begin
            status_next = pxedc_pkg::STATUS_NOT_PXE;
        end else if (walk_stat.msg_type != pxedc_pkg::MSG_DISCOVER &&
                     walk_stat.msg_type != pxedc_pkg::MSG_REQUEST) begin
            status_next = pxedc_pkg::STATUS_BAD_TYPE;
        end else begin
            status_next = pxedc_pkg::STATUS_OK;
        end
    end

    assign m_valid_next = accept_last ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || accept_last) begin
            count_reg     <= '0;
            op_ok_reg     <= 1'b0;
            cookie_ok_reg <= 1'b0;
            xid_reg       <= '0;
            flags_reg     <= '0;
            htype_reg     <= '0;
            hlen_reg      <= '0;
            giaddr_reg    <= '0;
            chaddr_reg    <= '0;
        end else begin
            count_reg     <= count_next;
            op_ok_reg     <= op_ok_next;
            cookie_ok_reg <= cookie_ok_next;
            xid_reg       <= xid_next;
            flags_reg     <= flags_next;
            htype_reg     <= htype_next;
            hlen_reg      <= hlen_next;
            giaddr_reg    <= giaddr_next;
            chaddr_reg    <= chaddr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_last) begin
            respond_reg    <= (status_next == pxedc_pkg::STATUS_OK);
            status_reg     <= status_next;
            if (status_next != pxedc_pkg::STATUS_OK) begin
                reply_reg <= pxedc_pkg::REPLY_NONE;
            end else if (walk_stat.msg_type == pxedc_pkg::MSG_DISCOVER) begin
                reply_reg <= pxedc_pkg::REPLY_OFFER;
            end else begin
                reply_reg <= pxedc_pkg::REPLY_ACK;
            end
            xid_out_reg    <= xid_next;
            flags_out_reg  <= flags_next;
            htype_out_reg  <= htype_next;
            hlen_out_reg   <= hlen_next;
            giaddr_out_reg <= giaddr_next;
            chaddr_out_reg <= chaddr_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_respond        = respond_reg;
    assign m_status         = status_reg;
    assign m_reply_msg_type = reply_reg;
    assign m_transaction_id = xid_out_reg;
    assign m_bootp_flags    = flags_out_reg;
    assign m_hw_type        = htype_out_reg;
    assign m_hw_len         = hlen_out_reg;
    assign m_relay_addr     = giaddr_out_reg;
    assign m_client_hw_addr = chaddr_out_reg;

    `PXEDC_ASSERT_NEXT(a_last_gives_verdict, aclk, aresetn, accept_last, m_valid_reg, "last word accepted but no verdict")
    `PXEDC_ASSERT_NEXT(a_last_clears_count, aclk, aresetn, accept_last, count_reg == '0, "byte count not cleared after verdict")
    `PXEDC_ASSERT(a_respond_matches_status, aclk, aresetn, !m_valid_reg || (respond_reg == (status_reg == pxedc_pkg::STATUS_OK)), "respond disagrees with status")
    `PXEDC_ASSERT(a_reply_type_legal, aclk, aresetn, !m_valid_reg || (respond_reg ? (reply_reg == pxedc_pkg::REPLY_OFFER || reply_reg == pxedc_pkg::REPLY_ACK) : (reply_reg == pxedc_pkg::REPLY_NONE)), "reply type inconsistent with respond")

endmodule

// ===== rtl/pxedc_opt_walker.sv =====
`timescale 1ns / 1ps

module pxedc_opt_walker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pxedc_pkg::walk_ctrl_t ctrl,
    output pxedc_pkg::walk_stat_t stat
);

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_END      = 8'd255;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_VENDOR   = 8'd60;
    localparam logic [3:0] TAG_LEN      = 4'd9;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // Lower-case "pxeclient".
    function automatic logic [7:0] tag_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h70;
            4'd1:    ch = 8'h78;
            4'd2:    ch = 8'h65;
            4'd3:    ch = 8'h63;
            4'd4:    ch = 8'h6C;
            4'd5:    ch = 8'h69;
            4'd6:    ch = 8'h65;
            4'd7:    ch = 8'h6E;
            4'd8:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    phase_t     phase_reg, phase_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] msg_type_reg, msg_type_next;
    logic [3:0] progress_reg, progress_next;
    logic       matching_reg, matching_next;
    logic       pxe_seen_reg, pxe_seen_next;

    always_comb begin
        phase_next     = phase_reg;
        code_next      = code_reg;
        remaining_next = remaining_reg;
        pending_next   = pending_reg;
        msg_type_next  = msg_type_reg;
        progress_next  = progress_reg;
        matching_next  = matching_reg;
        pxe_seen_next  = pxe_seen_reg;
        if (ctrl.byte_en) begin
            case (phase_reg)
                PH_CODE: begin
                    if (ctrl.data == OPT_END) begin
                        phase_next = PH_DONE;
                    end else if (ctrl.data != OPT_PAD) begin
                        code_next  = ctrl.data;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    remaining_next = ctrl.data;
                    progress_next  = 4'd0;
                    matching_next  = 1'b1;
                    pending_next   = 8'd0;
                    // An empty option completes with no effect.
                    phase_next = (ctrl.data == 8'd0) ? PH_CODE : PH_VAL;
                end
                PH_VAL: begin
                    if (progress_reg == 4'd0) begin
                        pending_next = ctrl.data;
                    end
                    if (progress_reg < TAG_LEN) begin
                        if (to_lower(ctrl.data) != tag_char(progress_reg)) begin
                            matching_next = 1'b0;
                        end
                        progress_next = progress_reg + 4'd1;
                    end
                    remaining_next = remaining_reg - 8'd1;
                    if (remaining_next == 8'd0) begin
                        phase_next = PH_CODE;
                        if (code_reg == OPT_MSG_TYPE && progress_next != 4'd0) begin
                            msg_type_next = pending_next;
                        end else if (code_reg == OPT_VENDOR && matching_next &&
                                     progress_next >= TAG_LEN) begin
                            pxe_seen_next = 1'b1;
                        end
                    end
                end
                default: begin
                    // Hold after the end option.
                end
            endcase
        end
    end

    assign stat.msg_type = msg_type_next;
    assign stat.pxe_seen = pxe_seen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            phase_reg     <= PH_CODE;
            code_reg      <= 8'd0;
            remaining_reg <= 8'd0;
            pending_reg   <= 8'd0;
            msg_type_reg  <= 8'd0;
            progress_reg  <= 4'd0;
            matching_reg  <= 1'b1;
            pxe_seen_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            remaining_reg <= remaining_next;
            pending_reg   <= pending_next;
            msg_type_reg  <= msg_type_next;
            progress_reg  <= progress_next;
            matching_reg  <= matching_next;
            pxe_seen_reg  <= pxe_seen_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int          MAX_BYTES      = 256;
    localparam int          CYCLE_LIMIT    = 600000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          MAX_REPORTS    = 40;
    localparam logic [7:0]  OP_BOOTREQUEST = 8'd1;
    localparam logic [7:0]  OPT_PAD        = 8'd0;
    localparam logic [7:0]  OPT_MSG_TYPE   = 8'd53;
    localparam logic [7:0]  OPT_CLASS_ID   = 8'd60;
    localparam logic [7:0]  OPT_END        = 8'd255;
    localparam logic [7:0]  MSG_INFORM     = 8'd8;
    localparam logic [71:0] PXE_TAG        = "pxeclient";

    typedef enum logic [1:0] {WALK_CODE, WALK_LEN, WALK_VALUE, WALK_DONE} walk_t;

    typedef struct {
        logic                 respond;
        pxedc_pkg::status_t   status;
        logic [2:0]           reply;
        logic [31:0]          xid;
        logic [15:0]          flags;
        logic [7:0]           htype;
        logic [7:0]           hlen;
        logic [31:0]          giaddr;
        logic [47:0]          chaddr;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_respond;
    logic [2:0]  m_status;
    logic [2:0]  m_reply_msg_type;
    logic [31:0] m_transaction_id;
    logic [15:0] m_bootp_flags;
    logic [7:0]  m_hw_type;
    logic [7:0]  m_hw_len;
    logic [31:0] m_relay_addr;
    logic [47:0] m_client_hw_addr;

    pxe_dhcp_request_classifier_top #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_respond        (m_respond),
        .m_status         (m_status),
        .m_reply_msg_type (m_reply_msg_type),
        .m_transaction_id (m_transaction_id),
        .m_bootp_flags    (m_bootp_flags),
        .m_hw_type        (m_hw_type),
        .m_hw_len         (m_hw_len),
        .m_relay_addr     (m_relay_addr),
        .m_client_hw_addr (m_client_hw_addr)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Classifier state mirrored for prediction
    int          seen_bytes;
    logic        op_good;
    logic        cookie_good;
    logic [31:0] cap_xid;
    logic [15:0] cap_flags;
    logic [7:0]  cap_htype;
    logic [7:0]  cap_hlen;
    logic [31:0] cap_giaddr;
    logic [47:0] cap_chaddr;
    walk_t       walk;
    logic [7:0]  opt_code;
    logic [7:0]  opt_left;
    logic [7:0]  first_val;
    logic [7:0]  cur_msg_type;
    int          val_seen;
    logic        tag_ok;
    logic        pxe_client;

    verdict_t    verdicts_due[$];
    logic [7:0]  pkt[$];
    string       pxe_name = "PXEClient";

    int          tx_idle_pct;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    int          errors;
    int          checked;
    int          replies_due;
    int          bytes_sent;
    int          pkts_sent;
    int          cycles;

    task automatic clear_classifier();
        seen_bytes   = 0;
        op_good      = 1'b0;
        cookie_good  = 1'b0;
        cap_xid      = '0;
        cap_flags    = '0;
        cap_htype    = '0;
        cap_hlen     = '0;
        cap_giaddr   = '0;
        cap_chaddr   = '0;
        walk         = WALK_CODE;
        opt_code     = '0;
        opt_left     = '0;
        first_val    = '0;
        cur_msg_type = '0;
        val_seen     = 0;
        tag_ok       = 1'b1;
        pxe_client   = 1'b0;
    endtask

    task automatic close_option();
        if (opt_code == OPT_MSG_TYPE && val_seen > 0)
            cur_msg_type = first_val;
        else if (opt_code == OPT_CLASS_ID && tag_ok && val_seen >= 9)
            pxe_client = 1'b1;
        walk = WALK_CODE;
    endtask

    // Advance the classifier by one word; queue a verdict at the last word.
    task automatic classify_byte(input logic [7:0] b, input logic lst);
        verdict_t   v;
        int         pos;
        logic [7:0] lower;
        pos = seen_bytes;
        if (pos < pxedc_pkg::HDR_LEN) begin
            case (pos)
                0: op_good = (b == OP_BOOTREQUEST);
                1: cap_htype = b;
                2: cap_hlen = b;
                4, 5, 6, 7: cap_xid[8*(7-pos) +: 8] = b;
                10, 11: cap_flags[8*(11-pos) +: 8] = b;
                24, 25, 26, 27: cap_giaddr[8*(27-pos) +: 8] = b;
                28, 29, 30, 31, 32, 33: cap_chaddr[8*(33-pos) +: 8] = b;
                236, 237, 238, 239:
                    cookie_good = (pos == 236 || cookie_good) &&
                                  (b == pxedc_pkg::MAGIC_COOKIE[8*(239-pos) +: 8]);
                default: ;
            endcase
        end else begin
            case (walk)
                WALK_CODE: begin
                    if (b == OPT_END) walk = WALK_DONE;
                    else if (b != OPT_PAD) begin
                        opt_code = b;
                        walk = WALK_LEN;
                    end
                end
                WALK_LEN: begin
                    opt_left  = b;
                    val_seen  = 0;
                    tag_ok    = 1'b1;
                    first_val = '0;
                    if (b == 8'd0) close_option();
                    else walk = WALK_VALUE;
                end
                WALK_VALUE: begin
                    if (val_seen == 0) first_val = b;
                    if (val_seen < 9) begin
                        lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                        if (lower != PXE_TAG[8*(8-val_seen) +: 8]) tag_ok = 1'b0;
                        val_seen++;
                    end
                    opt_left--;
                    if (opt_left == 8'd0) close_option();
                end
                default: ;
            endcase
        end
        if (seen_bytes < MAX_BYTES) seen_bytes++;

        if (lst) begin
            if (seen_bytes < pxedc_pkg::HDR_LEN) v.status = pxedc_pkg::STATUS_TOO_SHORT;
            else if (!op_good) v.status = pxedc_pkg::STATUS_NOT_REQ;
            else if (!cookie_good) v.status = pxedc_pkg::STATUS_BAD_COOKIE;
            else if (!pxe_client) v.status = pxedc_pkg::STATUS_NOT_PXE;
            else if (cur_msg_type != pxedc_pkg::MSG_DISCOVER &&
                     cur_msg_type != pxedc_pkg::MSG_REQUEST)
                v.status = pxedc_pkg::STATUS_BAD_TYPE;
            else v.status = pxedc_pkg::STATUS_OK;
            v.respond = (v.status == pxedc_pkg::STATUS_OK);
            v.reply   = !v.respond ? pxedc_pkg::REPLY_NONE :
                        (cur_msg_type == pxedc_pkg::MSG_DISCOVER) ? pxedc_pkg::REPLY_OFFER :
                        pxedc_pkg::REPLY_ACK;
            v.xid     = cap_xid;
            v.flags   = cap_flags;
            v.htype   = cap_htype;
            v.hlen    = cap_hlen;
            v.giaddr  = cap_giaddr;
            v.chaddr  = cap_chaddr;
            if (v.respond) replies_due++;
            verdicts_due.push_back(v);
            clear_classifier();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        if (errors < MAX_REPORTS)
            $display("verdict %0d %s: got %0h expected %0h", checked, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : watch_verdicts
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected verdict", 48'd1, 48'd0);
            end else begin
                want = verdicts_due.pop_front();
                if (m_respond !== want.respond)
                    report_mismatch("respond", m_respond, want.respond);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_reply_msg_type !== want.reply)
                    report_mismatch("reply_msg_type", m_reply_msg_type, want.reply);
                if (m_transaction_id !== want.xid)
                    report_mismatch("transaction_id", m_transaction_id, want.xid);
                if (m_bootp_flags !== want.flags)
                    report_mismatch("bootp_flags", m_bootp_flags, want.flags);
                if (m_hw_type !== want.htype)
                    report_mismatch("hw_type", m_hw_type, want.htype);
                if (m_hw_len !== want.hlen)
                    report_mismatch("hw_len", m_hw_len, want.hlen);
                if (m_relay_addr !== want.giaddr)
                    report_mismatch("relay_addr", m_relay_addr, want.giaddr);
                if (m_client_hw_addr !== want.chaddr)
                    report_mismatch("client_hw_addr", m_client_hw_addr, want.chaddr);
                checked++;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycles,
                     verdicts_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // Offer one word; valid stays up from the previous word unless an idle gap is taken.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        classify_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        pkts_sent++;
    endtask

    task automatic begin_header(input logic [7:0] op, input logic cookie_ok);
        pkt.delete();
        pkt.push_back(op);
        repeat (235) pkt.push_back(8'($urandom_range(255)));
        for (int i = 0; i < 4; i++) pkt.push_back(pxedc_pkg::MAGIC_COOKIE[8*(3-i) +: 8]);
        if (!cookie_ok) pkt[236 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    endtask

    task automatic add_msg_type(input logic [7:0] kind);
        pkt.push_back(OPT_MSG_TYPE);
        pkt.push_back(8'd1);
        pkt.push_back(kind);
    endtask

    task automatic add_class_id(input string id, input logic mix_case);
        logic [7:0] c;
        pkt.push_back(OPT_CLASS_ID);
        pkt.push_back(8'(id.len()));
        for (int i = 0; i < id.len(); i++) begin
            c = id[i];
            if (mix_case && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) &&
                $urandom_range(1))
                c ^= 8'h20;
            pkt.push_back(c);
        end
    endtask

    // Pads, a mixed-case class id and a request; options after the end marker are dead.
    task automatic test_pxe_request();
        begin_header(OP_BOOTREQUEST, 1'b1);
        repeat (2) pkt.push_back(OPT_PAD);
        add_class_id(pxe_name, 1'b1);
        add_msg_type(pxedc_pkg::MSG_REQUEST);
        pkt.push_back(OPT_END);
        add_msg_type(pxedc_pkg::MSG_DISCOVER);
        send_pkt();
    endtask

    // Last complete message type wins; an empty one keeps it, a cut-short one is dropped.
    task automatic test_message_type_rules();
        begin_header(OP_BOOTREQUEST, 1'b1);
        add_msg_type(pxedc_pkg::MSG_DISCOVER);
        add_class_id(pxe_name, 1'b1);
        add_msg_type(MSG_INFORM);
        pkt.push_back(OPT_MSG_TYPE);
        pkt.push_back(8'd0);
        pkt.push_back(OPT_MSG_TYPE);
        pkt.push_back(8'd1);
        send_pkt();
    endtask

    // Run past the byte counter's ceiling; the option walk must keep going.
    task automatic test_long_datagram();
        begin_header(OP_BOOTREQUEST, 1'b1);
        add_class_id(pxe_name, 1'b0);
        add_msg_type(pxedc_pkg::MSG_DISCOVER);
        while (pkt.size() < MAX_BYTES + 2) pkt.push_back(OPT_PAD);
        add_msg_type(pxedc_pkg::MSG_REQUEST);
        pkt.push_back(OPT_MSG_TYPE);
        pkt.push_back(8'd2);
        pkt.push_back(pxedc_pkg::MSG_DISCOVER);
        send_pkt();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (30) begin
            pkt.delete();
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(255)));
            send_pkt();
        end
    endtask

    initial begin
        s_valid     <= 1'b0;
        s_data_byte <= 8'd0;
        s_last      <= 1'b0;
        aresetn     <= 1'b0;
        clear_classifier();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_idle(28, 54);
        test_pxe_request();
        set_idle(54, 28);
        test_message_type_rules();
        set_idle(0, 0);
        test_backpressure();
        test_long_datagram();
        s_valid <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d datagrams (%0d bytes) under three idle mixes and a long receiver stall",
                 pkts_sent, bytes_sent);
        $display("Compared %0d verdicts, %0d proxy replies among them, %0d mismatches",
                 checked, replies_due, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
